// ===== design/dpth_pkg.sv =====
// Shared types and constants for the dotted path token hasher.
package dpth_pkg;

    localparam int MAX_SEGMENTS = 4;
    localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
    localparam int HASH_W       = 32;
    localparam int HASH_MULT    = 31;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_STAR = 8'h2A;

    typedef enum logic [2:0] {
        PH_START,
        PH_SEG,
        PH_STAR,
        PH_TAIL,
        PH_IGNORE,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TOKEN,
        KIND_WILD,
        KIND_ERROR,
        KIND_END
    } t_kind;

    localparam logic ERR_START = 1'b0;
    localparam logic ERR_DOT   = 1'b1;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       path_last;
    } t_in_req;

    typedef struct packed {
        t_kind                     kind;
        logic                      error_code;
        logic [1:0]                segment_slot;
        logic signed [HASH_W-1:0]  token_hash;
        logic                      path_end;
    } t_out_req;

    typedef struct packed {
        t_phase                phase;
        logic [SEG_CNT_W-1:0]  seg_count;
        logic [HASH_W-1:0]     hash;
    } t_state;

    typedef struct packed {
        t_state    nxt;
        logic      has_out;
        t_out_req  out;
    } t_step;

endpackage

// ===== design/dpth_step.sv =====
// Per-byte tokenizer step: next parser state and the optional result.
module dpth_step (
    input  dpth_pkg::t_state              i_state,
    input  dpth_pkg::t_in_req             i_req,
    input  logic [dpth_pkg::HASH_W-1:0]   i_wildcard_hash,
    output dpth_pkg::t_step               o_step
);

    logic                               is_dot;
    logic                               is_star;
    logic                               last;
    logic                               start_err;
    dpth_pkg::t_phase                   ph_cur;
    logic [dpth_pkg::SEG_CNT_W-1:0]     cnt_cur;
    logic [dpth_pkg::SEG_CNT_W-1:0]     cnt_inc;
    logic [dpth_pkg::HASH_W-1:0]        h_cur;
    logic [dpth_pkg::HASH_W-1:0]        h_mac;
    logic [dpth_pkg::HASH_W-1:0]        sx;
    dpth_pkg::t_state                   n_state;
    logic                               has_out;
    dpth_pkg::t_out_req                 res;

    assign is_dot    = (i_req.path_byte == dpth_pkg::CH_DOT);
    assign is_star   = (i_req.path_byte == dpth_pkg::CH_STAR);
    assign last      = i_req.path_last;
    assign sx        = {{(dpth_pkg::HASH_W-8){i_req.path_byte[7]}}, i_req.path_byte};

    // a path start opens segment zero; a leading dot goes straight to error
    assign start_err = (i_state.phase == dpth_pkg::PH_START) && is_dot;
    assign ph_cur    = (i_state.phase != dpth_pkg::PH_START) ? i_state.phase
                     : (is_dot ? dpth_pkg::PH_ERROR : dpth_pkg::PH_SEG);
    assign cnt_cur   = (i_state.phase == dpth_pkg::PH_START) ? '0 : i_state.seg_count;
    assign h_cur     = (i_state.phase == dpth_pkg::PH_START) ? '0 : i_state.hash;
    assign cnt_inc   = cnt_cur + dpth_pkg::SEG_CNT_W'(1);
    assign h_mac     = h_cur * dpth_pkg::HASH_W'(dpth_pkg::HASH_MULT) + sx;

    always_comb begin
        n_state.phase     = ph_cur;
        n_state.seg_count = cnt_cur;
        n_state.hash      = h_cur;
        case (ph_cur)
            dpth_pkg::PH_SEG: begin
                if (is_dot) begin
                    n_state.seg_count = cnt_inc;
                    n_state.hash      = '0;
                    n_state.phase     =
                        (cnt_inc >= dpth_pkg::SEG_CNT_W'(dpth_pkg::MAX_SEGMENTS))
                        ? dpth_pkg::PH_TAIL : dpth_pkg::PH_SEG;
                end else if (is_star) begin
                    n_state.seg_count = cnt_inc;
                    n_state.hash      = '0;
                    n_state.phase     = dpth_pkg::PH_STAR;
                end else begin
                    n_state.hash = h_mac;
                end
            end
            dpth_pkg::PH_STAR: begin
                // only a separator may follow a wildcard
                if (is_dot) begin
                    n_state.hash  = '0;
                    n_state.phase =
                        (cnt_cur >= dpth_pkg::SEG_CNT_W'(dpth_pkg::MAX_SEGMENTS))
                        ? dpth_pkg::PH_IGNORE : dpth_pkg::PH_SEG;
                end else begin
                    n_state.phase = dpth_pkg::PH_ERROR;
                end
            end
            dpth_pkg::PH_TAIL: begin
                if (is_dot) begin
                    n_state.phase = dpth_pkg::PH_IGNORE;
                end else if (is_star) begin
                    n_state.phase = dpth_pkg::PH_STAR;
                end
            end
            default: begin
                // drop the byte
            end
        endcase
        if (last) begin
            n_state.phase     = dpth_pkg::PH_START;
            n_state.seg_count = '0;
            n_state.hash      = '0;
        end
    end

    always_comb begin
        has_out          = 1'b0;
        res.kind         = dpth_pkg::KIND_TOKEN;
        res.error_code   = dpth_pkg::ERR_START;
        res.segment_slot = '0;
        res.token_hash   = '0;
        res.path_end     = last;
        if (start_err) begin
            has_out    = 1'b1;
            res.kind   = dpth_pkg::KIND_ERROR;
        end else begin
            case (ph_cur)
                dpth_pkg::PH_SEG: begin
                    if (is_dot) begin
                        has_out          = 1'b1;
                        res.segment_slot = cnt_cur[1:0];
                        res.token_hash   = h_cur;
                    end else if (is_star) begin
                        has_out          = 1'b1;
                        res.kind         = dpth_pkg::KIND_WILD;
                        res.segment_slot = cnt_cur[1:0];
                        res.token_hash   = i_wildcard_hash;
                    end else if (last) begin
                        has_out          = 1'b1;
                        res.segment_slot = cnt_cur[1:0];
                        res.token_hash   = h_mac;
                    end
                end
                dpth_pkg::PH_STAR: begin
                    if (!is_dot) begin
                        has_out        = 1'b1;
                        res.kind       = dpth_pkg::KIND_ERROR;
                        res.error_code = dpth_pkg::ERR_DOT;
                    end
                end
                default: begin
                    // no result
                end
            endcase
        end
        if (last && !has_out) begin
            has_out  = 1'b1;
            res.kind = dpth_pkg::KIND_END;
        end
    end

    assign o_step = {n_state, has_out, res};

endmodule

// ===== design/dotted_path_token_hasher.sv =====
// Dotted path tokenizer with a per-segment polynomial hash, top level.
//
// Usage: send a path one byte per request on the input channel (valid/ready),
// with path_last set on its final byte. Each byte yields zero or one result
// on the output channel: a token (slot and 31-multiplier hash of the segment),
// a wildcard token (slot and the configured wildcard hash), an error, or a
// bare path-end marker. The final byte of a path always yields a result with
// path_end set. Up to four segments are tokenized; in the rest only a star is
// checked, for a dot after it. A result is written to the output register in
// the cycle after its byte is accepted. One byte is taken per cycle unless
// a full output register stalls; the hash multiply-add and phase update are
// combinational. The input is ready whenever the output register is empty or
// being taken, so a stalled receiver holds the pending result and blocks
// further input only when it is full. Write the wildcard hash register through
// i_cfg_we/i_cfg_data only while the block is idle; it is not enforced.
// Reset (synchronous, active low) returns to path start, clears the
// hash and segment count, empties the output register and clears the
// wildcard hash to zero.
module dotted_path_token_hasher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dpth_pkg::t_in_req             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dpth_pkg::t_out_req            o_out,
    input  logic                          i_cfg_we,
    input  logic [dpth_pkg::HASH_W-1:0]   i_cfg_data
);

    dpth_pkg::t_state              r_state;
    dpth_pkg::t_out_req            r_out;
    logic                          r_out_valid;
    logic [dpth_pkg::HASH_W-1:0]   r_wildcard_hash;

    dpth_pkg::t_step               step;
    logic                          accept;

    dpth_step u_step (
        .i_state         (r_state),
        .i_req           (i_in),
        .i_wildcard_hash (r_wildcard_hash),
        .o_step          (step)
    );

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= dpth_pkg::PH_START;
            r_state.seg_count <= '0;
            r_state.hash      <= '0;
            r_out_valid       <= 1'b0;
            r_wildcard_hash   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wildcard_hash <= i_cfg_data;
            end
            if (accept) begin
                r_state <= step.nxt;
            end
            if (accept && step.has_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step.has_out) begin
            r_out <= step.out;
        end
    end

    // the last byte of a path always closes it with a result and a fresh state
    a_last_gives_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.path_last |=> o_out_valid && o_out.path_end
            && r_state.phase == dpth_pkg::PH_START && r_state.seg_count == '0)
        else $error("path end not reported or state not returned to start");

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == dpth_pkg::PH_SEG
            |-> r_state.seg_count < dpth_pkg::SEG_CNT_W'(dpth_pkg::MAX_SEGMENTS))
        else $error("open segment beyond the segment limit");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == dpth_pkg::KIND_ERROR || o_out.kind == dpth_pkg::KIND_END)
            |-> o_out.token_hash == '0 && o_out.segment_slot == '0)
        else $error("error or end result carries a slot or hash");

endmodule

// ===== sim/tb_dotted_path_token_hasher.sv =====
// Self-checking testbench for the dotted path token hasher: directed and random paths.
module tb_dotted_path_token_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the tokenizer state and holds the results still owed by the block.
    class hash_scoreboard;
        dpth_pkg::t_out_req expected[$];
        logic [31:0]        wild_hash;
        dpth_pkg::t_phase   phase;
        logic [2:0]         seg_cnt;
        logic [31:0]        run_hash;
        int                 checked;
        int                 errors;

        function new();
            wild_hash = '0;
            phase     = dpth_pkg::PH_START;
            seg_cnt   = '0;
            run_hash  = '0;
            checked   = 0;
            errors    = 0;
        endfunction

        function void set_wildcard(logic [31:0] v);
            wild_hash = v;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function dpth_pkg::t_out_req make_result(dpth_pkg::t_kind k, logic code,
                                                 logic [1:0] slot, logic [31:0] h,
                                                 logic fin);
            dpth_pkg::t_out_req r;
            r.kind         = k;
            r.error_code   = code;
            r.segment_slot = slot;
            r.token_hash   = h;
            r.path_end     = fin;
            return r;
        endfunction

        // Advance the tokenizer by one accepted byte.
        function void note_request(dpth_pkg::t_in_req req);
            logic [7:0]         b;
            logic               last;
            bit                 got;
            dpth_pkg::t_out_req res;
            b    = req.path_byte;
            last = req.path_last;
            got  = 0;
            res  = '0;
            if (phase == dpth_pkg::PH_START) begin
                seg_cnt  = '0;
                run_hash = '0;
                if (b == dpth_pkg::CH_DOT) begin
                    res   = make_result(dpth_pkg::KIND_ERROR, dpth_pkg::ERR_START, 2'd0,
                                        32'd0, last);
                    got   = 1;
                    phase = dpth_pkg::PH_ERROR;
                end else begin
                    phase = dpth_pkg::PH_SEG;
                end
            end
            if (!got) begin
                case (phase)
                    dpth_pkg::PH_SEG: begin
                        if (b == dpth_pkg::CH_DOT) begin
                            res      = make_result(dpth_pkg::KIND_TOKEN, 1'b0, seg_cnt[1:0],
                                                   run_hash, last);
                            got      = 1;
                            seg_cnt  = seg_cnt + 3'd1;
                            run_hash = '0;
                            phase    = (seg_cnt >= dpth_pkg::MAX_SEGMENTS)
                                       ? dpth_pkg::PH_TAIL : dpth_pkg::PH_SEG;
                        end else if (b == dpth_pkg::CH_STAR) begin
                            res      = make_result(dpth_pkg::KIND_WILD, 1'b0, seg_cnt[1:0],
                                                   wild_hash, last);
                            got      = 1;
                            seg_cnt  = seg_cnt + 3'd1;
                            run_hash = '0;
                            phase    = dpth_pkg::PH_STAR;
                        end else begin
                            run_hash = run_hash * 32'(dpth_pkg::HASH_MULT) + {{24{b[7]}}, b};
                            if (last) begin
                                res = make_result(dpth_pkg::KIND_TOKEN, 1'b0, seg_cnt[1:0],
                                                  run_hash, 1'b1);
                                got = 1;
                            end
                        end
                    end
                    dpth_pkg::PH_STAR: begin
                        if (b == dpth_pkg::CH_DOT) begin
                            run_hash = '0;
                            phase    = (seg_cnt >= dpth_pkg::MAX_SEGMENTS)
                                       ? dpth_pkg::PH_IGNORE : dpth_pkg::PH_SEG;
                        end else begin
                            res   = make_result(dpth_pkg::KIND_ERROR, dpth_pkg::ERR_DOT, 2'd0,
                                                32'd0, last);
                            got   = 1;
                            phase = dpth_pkg::PH_ERROR;
                        end
                    end
                    dpth_pkg::PH_TAIL: begin
                        // a star past the last slot still demands a dot after it
                        if (b == dpth_pkg::CH_DOT)
                            phase = dpth_pkg::PH_IGNORE;
                        else if (b == dpth_pkg::CH_STAR)
                            phase = dpth_pkg::PH_STAR;
                    end
                    default: ;
                endcase
            end
            if (last) begin
                if (!got) begin
                    res = make_result(dpth_pkg::KIND_END, 1'b0, 2'd0, 32'd0, 1'b1);
                    got = 1;
                end
                phase    = dpth_pkg::PH_START;
                seg_cnt  = '0;
                run_hash = '0;
            end
            if (got)
                expected.push_back(res);
        endfunction

        function void check_result(dpth_pkg::t_out_req act);
            dpth_pkg::t_out_req want;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind %s code %0d slot %0d hash %0d end %0d",
                             act.kind.name(), act.error_code, act.segment_slot,
                             act.token_hash, act.path_end);
                return;
            end
            want = expected.pop_front();
            checked++;
            if (act.kind !== want.kind || act.error_code !== want.error_code ||
                act.segment_slot !== want.segment_slot ||
                act.token_hash !== want.token_hash || act.path_end !== want.path_end) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp kind %s code %0d slot %0d hash %0d end %0d",
                             want.kind.name(), want.error_code, want.segment_slot,
                             want.token_hash, want.path_end);
                    $display("          got kind %s code %0d slot %0d hash %0d end %0d",
                             act.kind.name(), act.error_code, act.segment_slot,
                             act.token_hash, act.path_end);
                end
            end
        endfunction
    endclass

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    dpth_pkg::t_in_req           i_in       = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b1;
    dpth_pkg::t_out_req          o_out;
    logic                        i_cfg_we   = 1'b0;
    logic [dpth_pkg::HASH_W-1:0] i_cfg_data = '0;

    hash_scoreboard sb = new();
    logic [7:0] path_q[$];
    bit idle_en    = 1'b0;
    int stall_left = 0;
    int items_sent = 0;
    int paths_sent = 0;
    int cfg_writes = 0;

    dotted_path_token_hasher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: check accepted results, stall in random bursts.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result(o_out);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0)
                    i_out_ready <= 1'b1;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 10);
            end
        end
    end

    task automatic send_request(logic [7:0] b, logic last);
        dpth_pkg::t_in_req req;
        req.path_byte = b;
        req.path_last = last;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
        items_sent++;
    endtask

    task automatic send_path();
        for (int i = 0; i < path_q.size(); i++)
            send_request(path_q[i], i == path_q.size() - 1);
        paths_sent++;
    endtask

    task automatic send_text(string s);
        path_q.delete();
        for (int i = 0; i < s.len(); i++)
            path_q.push_back(s[i]);
        send_path();
    endtask

    // Drain the block, then load a new wildcard hash.
    task automatic write_wildcard(logic [31:0] v);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_wildcard(v);
        cfg_writes++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) < 6)
            return 8'(8'h61 + $urandom_range(0, 25));
        b = 8'($urandom_range(0, 255));
        if (b == dpth_pkg::CH_DOT || b == dpth_pkg::CH_STAR)
            b = b ^ 8'h80;
        return b;
    endfunction

    task automatic random_path();
        int nseg;
        int len;
        int pick;
        path_q.delete();
        if ($urandom_range(0, 9) < 8) begin
            // well-formed: segments of plain bytes or a lone star, split by dots
            nseg = $urandom_range(1, 6);
            for (int s = 0; s < nseg; s++) begin
                if (s != 0)
                    path_q.push_back(dpth_pkg::CH_DOT);
                if ($urandom_range(0, 9) == 0) begin
                    path_q.push_back(dpth_pkg::CH_STAR);
                end else begin
                    len = (s == 0) ? $urandom_range(1, 5) : $urandom_range(0, 5);
                    for (int k = 0; k < len; k++)
                        path_q.push_back(plain_byte());
                end
            end
            if ($urandom_range(0, 9) == 0)
                path_q.push_back(dpth_pkg::CH_DOT);
        end else begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0: path_q.push_back(dpth_pkg::CH_DOT);
                    1: path_q.push_back(dpth_pkg::CH_STAR);
                    2: path_q.push_back(plain_byte());
                    default: path_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        if (path_q.size() == 0)
            path_q.push_back(plain_byte());
        send_path();
    endtask

    initial begin
        logic [31:0] wv;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed paths with the wildcard hash at its reset value.
        send_text(".a");
        send_text("*");
        path_q.delete();
        path_q.push_back(8'h80);
        path_q.push_back(8'hFF);
        path_q.push_back(dpth_pkg::CH_DOT);
        path_q.push_back(8'h00);
        path_q.push_back(8'h7F);
        send_path();
        send_text("a..*.b.");
        send_text("a.b.c.d.*x");

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: wv = 32'h7FFF_FFFF;
                1: wv = 32'h8000_0000;
                2: wv = $urandom;
                3: wv = 32'hFFFF_FFFF;
                default: wv = 32'h0000_0000;
            endcase
            write_wildcard(wv);
            while (items_sent < 25 + (p + 1) * 350) begin
                // hold idling off in the last part of the run
                idle_en = (p < 4) && ($urandom_range(0, 5) != 0);
                random_path();
            end
        end
        idle_en = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("run covered %0d paths, %0d bytes and %0d checked results", paths_sent,
                 items_sent, sb.checked);
        $display("wildcard hash loaded %0d times, %0d mismatches", cfg_writes, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
